/* rtl/core/tqs_pkg.sv */
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// tqs_pkg
// shared types and constants of the timer queue scheduler
// ---------------------------------------------------------------------------
package tqs_pkg;

    localparam int DEPTH_DEF   = 16;
    localparam int MAX_RESULTS = 16;
    localparam int NW          = $clog2(MAX_RESULTS + 1);
    localparam int LW          = $clog2(MAX_RESULTS);

    localparam int TICK_W   = 64;
    localparam int DELAY_W  = 32;
    localparam int HANDLE_W = 16;
    localparam int S_DATA_W = 120;
    localparam int M_DATA_W = 80;

    typedef enum logic [1:0] {
        OP_RESERVE    = 2'd0,
        OP_DISTRIBUTE = 2'd1,
        OP_CLEAR      = 2'd2,
        OP_UNUSED     = 2'd3
    } op_t;

    typedef enum logic [2:0] {
        KIND_DUE      = 3'd0,
        KIND_ACCEPTED = 3'd1,
        KIND_REJECTED = 3'd2,
        KIND_NONE_DUE = 3'd3,
        KIND_CLEARED  = 3'd4
    } kind_t;

    typedef enum logic [3:0] {
        ACT_NONE,
        ACT_LOAD,
        ACT_INS_START,
        ACT_REIN_START,
        ACT_REIN_SKIP,
        ACT_POP_INIT,
        ACT_CLEAR,
        ACT_RD_INS,
        ACT_SHIFT,
        ACT_WR_NEW,
        ACT_RD_HEAD,
        ACT_POP_HIT,
        ACT_EMIT_END,
        ACT_EMIT_KIND
    } act_t;

    typedef struct packed {
        act_t  act;
        kind_t kind;
    } cmd_t;

    typedef struct packed {
        op_t  op;
        logic full;
        logic count_zero;
        logic pos_zero;
        logic rd_gt;
        logic rd_le_now;
        logic n_max;
        logic rein_left;
        logic pend_v;
        logic out_free;
    } status_t;

endpackage

/* rtl/core/tqs_ctrl.sv */
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// tqs_ctrl
// sequencer for reserve, distribute, clear and periodic reinsertion
// ---------------------------------------------------------------------------
module tqs_ctrl (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             s_tvalid,
    output logic             s_tready,
    input  tqs_pkg::status_t st,
    output tqs_pkg::cmd_t    cmd
);
    import tqs_pkg::*;

    typedef enum logic [3:0] {
        S_IDLE, S_DECODE, S_INS_RD, S_INS_CMP, S_INS_WR,
        S_POP_RD, S_POP_CMP, S_POP_END, S_REIN, S_RESULT
    } state_t;

    state_t state_reg, state_next;
    logic   rein_reg, rein_next;
    kind_t  kind_reg, kind_next;
    act_t   act;

    always_comb begin
        state_next = state_reg;
        rein_next  = rein_reg;
        kind_next  = kind_reg;
        act        = ACT_NONE;
        s_tready   = 1'b0;
        case (state_reg)
            S_IDLE: begin
                s_tready = 1'b1;
                if (s_tvalid) begin
                    act        = ACT_LOAD;
                    state_next = S_DECODE;
                end
            end
            S_DECODE: begin
                case (st.op)
                    OP_RESERVE: begin
                        if (st.full) begin
                            kind_next  = KIND_REJECTED;
                            state_next = S_RESULT;
                        end else begin
                            act        = ACT_INS_START;
                            rein_next  = 1'b0;
                            state_next = S_INS_RD;
                        end
                    end
                    OP_DISTRIBUTE: begin
                        act        = ACT_POP_INIT;
                        state_next = S_POP_RD;
                    end
                    OP_CLEAR: begin
                        act        = ACT_CLEAR;
                        kind_next  = KIND_CLEARED;
                        state_next = S_RESULT;
                    end
                    default: state_next = S_IDLE;
                endcase
            end
            S_INS_RD: begin
                if (st.pos_zero) begin
                    state_next = S_INS_WR;
                end else begin
                    act        = ACT_RD_INS;
                    state_next = S_INS_CMP;
                end
            end
            S_INS_CMP: begin
                if (st.rd_gt) begin
                    act        = ACT_SHIFT;
                    state_next = S_INS_RD;
                end else begin
                    state_next = S_INS_WR;
                end
            end
            S_INS_WR: begin
                act = ACT_WR_NEW;
                if (rein_reg) begin
                    state_next = S_REIN;
                end else begin
                    kind_next  = KIND_ACCEPTED;
                    state_next = S_RESULT;
                end
            end
            S_POP_RD: begin
                if (!st.count_zero && !st.n_max) begin
                    act        = ACT_RD_HEAD;
                    state_next = S_POP_CMP;
                end else begin
                    state_next = S_POP_END;
                end
            end
            S_POP_CMP: begin
                if (st.rd_le_now) begin
                    if (!st.pend_v || st.out_free) begin
                        act        = ACT_POP_HIT;
                        state_next = S_POP_RD;
                    end
                end else begin
                    state_next = S_POP_END;
                end
            end
            S_POP_END: begin
                if (st.out_free) begin
                    act        = ACT_EMIT_END;
                    state_next = S_REIN;
                end
            end
            S_REIN: begin
                if (st.rein_left) begin
                    if (!st.full) begin
                        act        = ACT_REIN_START;
                        rein_next  = 1'b1;
                        state_next = S_INS_RD;
                    end else begin
                        act = ACT_REIN_SKIP;
                    end
                end else begin
                    state_next = S_IDLE;
                end
            end
            S_RESULT: begin
                if (st.out_free) begin
                    act        = ACT_EMIT_KIND;
                    state_next = S_IDLE;
                end
            end
            default: state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= S_IDLE;
            rein_reg  <= 1'b0;
            kind_reg  <= KIND_NONE_DUE;
        end else begin
            state_reg <= state_next;
            rein_reg  <= rein_next;
            kind_reg  <= kind_next;
        end
    end

    assign cmd.act  = act;
    assign cmd.kind = kind_reg;

endmodule

/* rtl/core/tqs_dp.sv */
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// tqs_dp
// sorted job store on a circular memory, item registers and result register
// ---------------------------------------------------------------------------
module tqs_dp #(
    parameter int DEPTH = tqs_pkg::DEPTH_DEF
) (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic [1:0]                    s_tuser,
    input  logic [tqs_pkg::S_DATA_W-1:0]  s_tdata,
    output logic                          m_tvalid,
    input  logic                          m_tready,
    output logic [tqs_pkg::M_DATA_W-1:0]  m_tdata,
    output logic [2:0]                    m_tuser,
    output logic                          m_tlast,
    input  tqs_pkg::cmd_t                 cmd,
    output tqs_pkg::status_t              st
);
    import tqs_pkg::*;

    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);
    localparam int MW = TICK_W + DELAY_W + HANDLE_W;

    // item registers
    op_t                 op_reg;
    logic [TICK_W-1:0]   now_reg;
    logic [DELAY_W-1:0]  delay_reg;
    logic                rep_reg;
    logic [HANDLE_W-1:0] id_reg;

    // store bookkeeping
    logic [AW-1:0]       head_reg;
    logic [CW-1:0]       count_reg;
    logic [CW-1:0]       pos_reg;

    // entry being inserted
    logic [TICK_W-1:0]   ins_due_reg;
    logic [DELAY_W-1:0]  ins_per_reg;
    logic [HANDLE_W-1:0] ins_hdl_reg;

    // distribute bookkeeping
    logic [NW-1:0]       n_reg;
    logic [NW-1:0]       nr_reg;
    logic [NW-1:0]       ri_reg;
    logic                pend_v_reg;
    logic [TICK_W-1:0]   pend_due_reg;
    logic [HANDLE_W-1:0] pend_hdl_reg;
    logic [DELAY_W-1:0]  list_per [MAX_RESULTS];
    logic [HANDLE_W-1:0] list_hdl [MAX_RESULTS];

    // result register
    logic                out_v_reg;
    logic                out_v_next;
    kind_t               out_kind_reg;
    logic [HANDLE_W-1:0] out_hdl_reg;
    logic [TICK_W-1:0]   out_tick_reg;
    logic                out_last_reg;

    // memory
    logic [MW-1:0]       mem [DEPTH];
    logic [MW-1:0]       rd_q;
    logic                rd_en, wr_en;
    logic [AW-1:0]       rd_addr, wr_addr;
    logic [MW-1:0]       wr_data;

    logic [TICK_W-1:0]   rd_due;
    logic [DELAY_W-1:0]  rd_per;
    logic [HANDLE_W-1:0] rd_hdl;
    logic [AW-1:0]       pos_lo, pos_m1;
    logic                out_free;

    assign rd_due = rd_q[MW-1 -: TICK_W];
    assign rd_per = rd_q[HANDLE_W +: DELAY_W];
    assign rd_hdl = rd_q[HANDLE_W-1:0];

    function automatic logic [AW-1:0] phys(input logic [AW-1:0] hd, input logic [AW-1:0] l);
        logic [AW:0] s;
        s = {1'b0, hd} + {1'b0, l};
        if (s >= (AW+1)'(DEPTH))
            s = s - (AW+1)'(DEPTH);
        return s[AW-1:0];
    endfunction

    assign pos_lo   = pos_reg[AW-1:0];
    assign pos_m1   = pos_lo - AW'(1);
    assign out_free = !out_v_reg || m_tready;

    always_comb begin
        rd_en   = 1'b0;
        rd_addr = head_reg;
        wr_en   = 1'b0;
        wr_addr = phys(head_reg, pos_lo);
        wr_data = {ins_due_reg, ins_per_reg, ins_hdl_reg};
        case (cmd.act)
            ACT_RD_INS: begin
                rd_en   = 1'b1;
                rd_addr = phys(head_reg, pos_m1);
            end
            ACT_RD_HEAD: rd_en = 1'b1;
            ACT_SHIFT: begin
                wr_en   = 1'b1;
                wr_data = rd_q;
            end
            ACT_WR_NEW: wr_en = 1'b1;
            default: ;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (wr_en)
            mem[wr_addr] <= wr_data;
    end

    always_ff @(posedge aclk) begin
        if (rd_en)
            rd_q <= mem[rd_addr];
    end

    always_comb begin
        out_v_next = out_v_reg && !m_tready;
        case (cmd.act)
            ACT_POP_HIT: begin
                if (pend_v_reg)
                    out_v_next = 1'b1;
            end
            ACT_EMIT_END, ACT_EMIT_KIND: out_v_next = 1'b1;
            default: ;
        endcase
    end

    // control registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            head_reg   <= '0;
            count_reg  <= '0;
            pend_v_reg <= 1'b0;
            out_v_reg  <= 1'b0;
            n_reg      <= '0;
            nr_reg     <= '0;
            ri_reg     <= '0;
        end else begin
            out_v_reg <= out_v_next;
            case (cmd.act)
                ACT_CLEAR: begin
                    head_reg  <= '0;
                    count_reg <= '0;
                end
                ACT_POP_INIT: begin
                    n_reg      <= '0;
                    nr_reg     <= '0;
                    pend_v_reg <= 1'b0;
                end
                ACT_WR_NEW: count_reg <= count_reg + CW'(1);
                ACT_POP_HIT: begin
                    pend_v_reg <= 1'b1;
                    n_reg      <= n_reg + NW'(1);
                    if (rd_per != '0)
                        nr_reg <= nr_reg + NW'(1);
                    head_reg  <= phys(head_reg, AW'(1));
                    count_reg <= count_reg - CW'(1);
                end
                ACT_EMIT_END: ri_reg <= '0;
                ACT_REIN_START, ACT_REIN_SKIP: ri_reg <= ri_reg + NW'(1);
                default: ;
            endcase
        end
    end

    // payload registers
    always_ff @(posedge aclk) begin
        case (cmd.act)
            ACT_LOAD: begin
                op_reg    <= op_t'(s_tuser);
                now_reg   <= s_tdata[63:0];
                delay_reg <= s_tdata[95:64];
                rep_reg   <= s_tdata[96];
                id_reg    <= s_tdata[112:97];
            end
            ACT_INS_START: begin
                ins_due_reg <= now_reg + TICK_W'(delay_reg);
                ins_per_reg <= rep_reg ? delay_reg : '0;
                ins_hdl_reg <= id_reg;
                pos_reg     <= count_reg;
            end
            ACT_REIN_START: begin
                ins_due_reg <= now_reg + TICK_W'(list_per[ri_reg[LW-1:0]]);
                ins_per_reg <= list_per[ri_reg[LW-1:0]];
                ins_hdl_reg <= list_hdl[ri_reg[LW-1:0]];
                pos_reg     <= count_reg;
            end
            ACT_SHIFT: pos_reg <= pos_reg - CW'(1);
            ACT_POP_HIT: begin
                // the previous hit is now known not to be the final beat
                if (pend_v_reg) begin
                    out_kind_reg <= KIND_DUE;
                    out_hdl_reg  <= pend_hdl_reg;
                    out_tick_reg <= pend_due_reg;
                    out_last_reg <= 1'b0;
                end
                pend_due_reg <= rd_due;
                pend_hdl_reg <= rd_hdl;
                if (rd_per != '0) begin
                    list_per[nr_reg[LW-1:0]] <= rd_per;
                    list_hdl[nr_reg[LW-1:0]] <= rd_hdl;
                end
            end
            ACT_EMIT_END: begin
                out_last_reg <= 1'b1;
                if (pend_v_reg) begin
                    out_kind_reg <= KIND_DUE;
                    out_hdl_reg  <= pend_hdl_reg;
                    out_tick_reg <= pend_due_reg;
                end else begin
                    out_kind_reg <= KIND_NONE_DUE;
                    out_hdl_reg  <= '0;
                    out_tick_reg <= '0;
                end
            end
            ACT_EMIT_KIND: begin
                out_kind_reg <= cmd.kind;
                out_last_reg <= 1'b1;
                out_hdl_reg  <= (cmd.kind == KIND_ACCEPTED || cmd.kind == KIND_REJECTED)
                                ? id_reg : '0;
                out_tick_reg <= (cmd.kind == KIND_ACCEPTED) ? ins_due_reg : '0;
            end
            default: ;
        endcase
    end

    assign st.op         = op_reg;
    assign st.full       = (count_reg == CW'(DEPTH));
    assign st.count_zero = (count_reg == '0);
    assign st.pos_zero   = (pos_reg == '0);
    assign st.rd_gt      = (rd_due > ins_due_reg);
    assign st.rd_le_now  = (rd_due <= now_reg);
    assign st.n_max      = (n_reg == NW'(MAX_RESULTS));
    assign st.rein_left  = (ri_reg < nr_reg);
    assign st.pend_v     = pend_v_reg;
    assign st.out_free   = out_free;

    assign m_tvalid = out_v_reg;
    assign m_tuser  = out_kind_reg;
    assign m_tdata  = {out_tick_reg, out_hdl_reg};
    assign m_tlast  = out_last_reg;

endmodule

/* rtl/core/timer_queue_scheduler_core.sv */
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// timer_queue_scheduler_core
// bounded store of timed jobs kept in due-tick order with periodic reload
// ---------------------------------------------------------------------------
// channel  dir  tdata                                      tuser     tlast
// s_       in   now, delay, repeat_req, job_id (113 of 120) op        -
// m_       out  job_handle, fired_tick (80)                kind      last
//
// reserve: walks the store memory from the tail, moving each stored entry with a
// later due tick up one place (read, compare, shift), then writes the new entry
// distribute: pops due entries at the head (at most 16), then one reserve-like
// insert for each periodic entry that fired, skipped while the store is full;
// clear empties the store; one item at a time; a stalled m_ side holds the
// sequencer, no clearing pass after reset (entry count starts at zero)
// ---------------------------------------------------------------------------
module timer_queue_scheduler_core #(
    parameter int DEPTH = tqs_pkg::DEPTH_DEF
) (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          s_tvalid,
    output logic                          s_tready,
    // now[63:0], delay[95:64], repeat_req[96], job_id[112:97]
    input  logic [tqs_pkg::S_DATA_W-1:0]  s_tdata,
    // op[1:0]
    input  logic [1:0]                    s_tuser,
    output logic                          m_tvalid,
    input  logic                          m_tready,
    // job_handle[15:0], fired_tick[79:16]
    output logic [tqs_pkg::M_DATA_W-1:0]  m_tdata,
    // kind[2:0]
    output logic [2:0]                    m_tuser,
    output logic                          m_tlast
);
    import tqs_pkg::*;

    cmd_t    cmd;
    status_t st;

    tqs_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .st       (st),
        .cmd      (cmd)
    );

    tqs_dp #(.DEPTH(DEPTH)) u_dp (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tuser  (s_tuser),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .m_tlast  (m_tlast),
        .cmd      (cmd),
        .st       (st)
    );

    a_no_write_when_full: assert property (@(posedge aclk) disable iff (!aresetn)
        st.full |-> (cmd.act != ACT_WR_NEW))
        else $error("insert into full store");

    a_pop_needs_entry: assert property (@(posedge aclk) disable iff (!aresetn)
        (cmd.act == ACT_POP_HIT) |-> !st.count_zero)
        else $error("pop from empty store");

    a_pop_beat_room: assert property (@(posedge aclk) disable iff (!aresetn)
        (cmd.act == ACT_POP_HIT && st.pend_v) |-> st.out_free)
        else $error("result register overwritten");

    a_emit_sets_valid: assert property (@(posedge aclk) disable iff (!aresetn)
        (cmd.act == ACT_EMIT_KIND || cmd.act == ACT_EMIT_END) |=> m_tvalid && m_tlast)
        else $error("final beat not presented");

endmodule
